FILE: rtl/dmts_pkg.sv
// ============================================================================
// DNS minimum TTL scanner package
// Item types, parser phase codes and sizing constants shared by the block.
// ============================================================================
`default_nettype none

package dmts_pkg;

    // One message byte as it arrives on the input channel.
    typedef struct packed {
        logic [7:0] byte_value;
        logic       last_byte;
    } dmts_in_t;

    // One result item.
    typedef struct packed {
        logic [31:0] min_ttl;
        logic [15:0] answers_taken;
    } dmts_out_t;

    // A byte after classification by the front part.
    typedef struct packed {
        logic [7:0] byte_value;
        logic       last_byte;
        logic       is_zero;
        logic       is_ptr;
    } dmts_cls_t;

    // Queue status seen by the front part and the back part.
    typedef struct packed {
        logic full;
        logic not_empty;
    } dmts_qstat_t;

    localparam int unsigned DMTS_QUEUE_DEPTH = 4;

    localparam logic [7:0]  PTR_MASK   = 8'hC0;
    localparam logic [3:0]  HEADER_LEN = 4'd12;
    localparam logic [3:0]  FIXED_LAST = 4'd9;   // index of the tenth fixed byte
    localparam logic [15:0] QTAIL_LEN  = 16'd4;
    localparam logic [31:0] ALL_ONES32 = 32'hFFFF_FFFF;

    // Header byte offsets of the question and answer counts.
    localparam logic [3:0] OFS_QD_HI = 4'd4;
    localparam logic [3:0] OFS_QD_LO = 4'd5;
    localparam logic [3:0] OFS_AN_HI = 4'd6;
    localparam logic [3:0] OFS_AN_LO = 4'd7;

    // Fixed answer field offsets.
    localparam logic [3:0] FLD_TTL_FIRST = 4'd4;
    localparam logic [3:0] FLD_TTL_LAST  = 4'd7;
    localparam logic [3:0] FLD_RDLEN_HI  = 4'd8;

    // Parser phases.
    localparam logic [3:0] PH_HEADER  = 4'd0;
    localparam logic [3:0] PH_Q_NAME  = 4'd1;
    localparam logic [3:0] PH_Q_LABEL = 4'd2;
    localparam logic [3:0] PH_Q_PTR   = 4'd3;
    localparam logic [3:0] PH_Q_TAIL  = 4'd4;
    localparam logic [3:0] PH_A_NAME  = 4'd5;
    localparam logic [3:0] PH_A_LABEL = 4'd6;
    localparam logic [3:0] PH_A_PTR   = 4'd7;
    localparam logic [3:0] PH_A_FIXED = 4'd8;
    localparam logic [3:0] PH_A_RDATA = 4'd9;
    localparam logic [3:0] PH_DONE    = 4'd10;

endpackage

`default_nettype wire

FILE: rtl/dmts_front.sv
// ============================================================================
// DNS minimum TTL scanner front part
// Accepts message bytes, classifies them and hands them to the queue.
// ============================================================================
`default_nettype none

module dmts_front
    import dmts_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        byte_valid,
    output logic             byte_stall,
    input  wire dmts_in_t    byte_item,
    input  wire dmts_qstat_t qstat,
    output logic             push,
    output dmts_cls_t        push_item
);

    logic      stage_valid_reg;
    logic      stage_valid_next;
    dmts_cls_t stage_item_reg;
    logic      accept;

    assign push       = stage_valid_reg && !qstat.full;
    assign push_item  = stage_item_reg;
    // The stage can take a byte whenever it is empty or is moving on this cycle.
    assign byte_stall = stage_valid_reg && qstat.full;
    assign accept     = byte_valid && !byte_stall;

    always_comb
    begin
        stage_valid_next = stage_valid_reg;
        if (accept)
        begin
            stage_valid_next = 1'b1;
        end
        else if (push)
        begin
            stage_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            stage_item_reg.byte_value <= byte_item.byte_value;
            stage_item_reg.last_byte  <= byte_item.last_byte;
            stage_item_reg.is_zero    <= (byte_item.byte_value == 8'd0);
            stage_item_reg.is_ptr     <= ((byte_item.byte_value & PTR_MASK) == PTR_MASK);
        end
    end

endmodule

`default_nettype wire

FILE: rtl/dmts_queue.sv
// ============================================================================
// DNS minimum TTL scanner queue
// Short first-in first-out buffer between the front and back parts.
// ============================================================================
`default_nettype none

module dmts_queue
    import dmts_pkg::*;
#(
    parameter int unsigned DEPTH = DMTS_QUEUE_DEPTH
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      push,
    input  wire dmts_cls_t push_item,
    input  wire logic      pop,
    output dmts_cls_t      head_item,
    output dmts_qstat_t    qstat
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    dmts_cls_t     mem [DEPTH];
    logic [AW-1:0] wr_ptr_reg;
    logic [AW-1:0] wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg;
    logic [AW-1:0] rd_ptr_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;

    assign head_item       = mem[rd_ptr_reg];
    assign qstat.full      = (count_reg == FULL_CNT);
    assign qstat.not_empty = (count_reg != '0);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/dmts_parser.sv
// ============================================================================
// DNS minimum TTL scanner back part
// Walks messages one byte per cycle when fed and unstalled; registers the result.
// ============================================================================
`default_nettype none

module dmts_parser
    import dmts_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire dmts_qstat_t qstat,
    input  wire dmts_cls_t   head_item,
    output logic             pop,
    output logic             result_valid,
    input  wire logic        result_stall,
    output dmts_out_t        result_item
);

    logic [3:0]  phase_reg,   phase_next;
    logic [3:0]  seen_reg,    seen_next;
    logic [15:0] qtotal_reg,  qtotal_next;
    logic [15:0] atotal_reg,  atotal_next;
    logic [15:0] left_reg,    left_next;
    logic [15:0] skip_reg,    skip_next;
    logic [3:0]  field_reg,   field_next;
    logic [31:0] ttl_reg,     ttl_next;
    logic [31:0] minimum_reg, minimum_next;
    logic [15:0] taken_reg,   taken_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    dmts_out_t   out_item_reg;

    logic [7:0]  b;
    logic [3:0]  seen_inc;
    logic [15:0] skip_dec;
    logic [15:0] left_dec;
    logic [15:0] rdlen;
    logic        finish;

    assign b        = head_item.byte_value;
    assign seen_inc = seen_reg + 4'd1;
    assign skip_dec = skip_reg - 16'd1;
    assign left_dec = left_reg - 16'd1;
    assign rdlen    = {skip_reg[7:0], b};

    // A non-final byte never waits; the final one needs the result register free.
    assign pop    = qstat.not_empty &&
                    (!head_item.last_byte || !out_valid_reg || !result_stall);
    assign finish = pop && head_item.last_byte;

    assign result_valid = out_valid_reg;
    assign result_item  = out_item_reg;

    always_comb
    begin
        phase_next   = phase_reg;
        seen_next    = seen_reg;
        qtotal_next  = qtotal_reg;
        atotal_next  = atotal_reg;
        left_next    = left_reg;
        skip_next    = skip_reg;
        field_next   = field_reg;
        ttl_next     = ttl_reg;
        minimum_next = minimum_reg;
        taken_next   = taken_reg;

        if (pop)
        begin
            unique case (phase_reg)
                PH_HEADER:
                begin
                    if (seen_reg == OFS_QD_HI || seen_reg == OFS_QD_LO)
                    begin
                        qtotal_next = {qtotal_reg[7:0], b};
                    end
                    else if (seen_reg == OFS_AN_HI || seen_reg == OFS_AN_LO)
                    begin
                        atotal_next = {atotal_reg[7:0], b};
                    end
                    seen_next = seen_inc;
                    if (seen_inc == HEADER_LEN)
                    begin
                        if (atotal_next == 16'd0)
                        begin
                            phase_next = PH_DONE;
                        end
                        else if (qtotal_next != 16'd0)
                        begin
                            left_next  = qtotal_next;
                            phase_next = PH_Q_NAME;
                        end
                        else
                        begin
                            left_next  = atotal_next;
                            phase_next = PH_A_NAME;
                        end
                    end
                end
                PH_Q_NAME:
                begin
                    if (head_item.is_zero)
                    begin
                        skip_next  = QTAIL_LEN;
                        phase_next = PH_Q_TAIL;
                    end
                    else if (head_item.is_ptr)
                    begin
                        phase_next = PH_Q_PTR;
                    end
                    else
                    begin
                        skip_next  = {8'd0, b};
                        phase_next = PH_Q_LABEL;
                    end
                end
                PH_Q_LABEL:
                begin
                    skip_next = skip_dec;
                    if (skip_dec == 16'd0)
                    begin
                        phase_next = PH_Q_NAME;
                    end
                end
                PH_Q_PTR:
                begin
                    skip_next  = QTAIL_LEN;
                    phase_next = PH_Q_TAIL;
                end
                PH_Q_TAIL:
                begin
                    skip_next = skip_dec;
                    if (skip_dec == 16'd0)
                    begin
                        left_next = left_dec;
                        if (left_dec == 16'd0)
                        begin
                            left_next  = atotal_reg;
                            phase_next = (atotal_reg == 16'd0) ? PH_DONE : PH_A_NAME;
                        end
                        else
                        begin
                            phase_next = PH_Q_NAME;
                        end
                    end
                end
                PH_A_NAME:
                begin
                    if (head_item.is_zero)
                    begin
                        field_next = 4'd0;
                        phase_next = PH_A_FIXED;
                    end
                    else if (head_item.is_ptr)
                    begin
                        phase_next = PH_A_PTR;
                    end
                    else
                    begin
                        skip_next  = {8'd0, b};
                        phase_next = PH_A_LABEL;
                    end
                end
                PH_A_LABEL:
                begin
                    skip_next = skip_dec;
                    if (skip_dec == 16'd0)
                    begin
                        phase_next = PH_A_NAME;
                    end
                end
                PH_A_PTR:
                begin
                    field_next = 4'd0;
                    phase_next = PH_A_FIXED;
                end
                PH_A_FIXED:
                begin
                    if (field_reg >= FLD_TTL_FIRST && field_reg <= FLD_TTL_LAST)
                    begin
                        ttl_next = {ttl_reg[23:0], b};
                    end
                    else if (field_reg == FLD_RDLEN_HI)
                    begin
                        skip_next = {8'd0, b};
                    end
                    if (field_reg >= FIXED_LAST)
                    begin
                        // All ten fixed bytes are in: the TTL is final.
                        skip_next  = rdlen;
                        taken_next = taken_reg + 16'd1;
                        if (ttl_reg < minimum_reg)
                        begin
                            minimum_next = ttl_reg;
                        end
                        field_next = 4'd0;
                        if (rdlen == 16'd0)
                        begin
                            left_next  = left_dec;
                            phase_next = (left_dec == 16'd0) ? PH_DONE : PH_A_NAME;
                        end
                        else
                        begin
                            phase_next = PH_A_RDATA;
                        end
                    end
                    else
                    begin
                        field_next = field_reg + 4'd1;
                    end
                end
                PH_A_RDATA:
                begin
                    skip_next = skip_dec;
                    if (skip_dec == 16'd0)
                    begin
                        left_next  = left_dec;
                        phase_next = (left_dec == 16'd0) ? PH_DONE : PH_A_NAME;
                    end
                end
                default:
                begin
                    // Done or an unused code: the byte is ignored.
                end
            endcase
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (finish)
        begin
            out_valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HEADER;
            seen_reg      <= '0;
            qtotal_reg    <= '0;
            atotal_reg    <= '0;
            left_reg      <= '0;
            skip_reg      <= '0;
            field_reg     <= '0;
            ttl_reg       <= '0;
            minimum_reg   <= ALL_ONES32;
            taken_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (finish)
            begin
                // The message is over: start the next one from a clean state.
                phase_reg   <= PH_HEADER;
                seen_reg    <= '0;
                qtotal_reg  <= '0;
                atotal_reg  <= '0;
                left_reg    <= '0;
                skip_reg    <= '0;
                field_reg   <= '0;
                ttl_reg     <= '0;
                minimum_reg <= ALL_ONES32;
                taken_reg   <= '0;
            end
            else
            begin
                phase_reg   <= phase_next;
                seen_reg    <= seen_next;
                qtotal_reg  <= qtotal_next;
                atotal_reg  <= atotal_next;
                left_reg    <= left_next;
                skip_reg    <= skip_next;
                field_reg   <= field_next;
                ttl_reg     <= ttl_next;
                minimum_reg <= minimum_next;
                taken_reg   <= taken_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (finish)
        begin
            out_item_reg.min_ttl       <= (minimum_next == ALL_ONES32) ? 32'd0 : minimum_next;
            out_item_reg.answers_taken <= taken_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/dns_min_ttl_scanner_core.sv
// ============================================================================
// DNS minimum TTL scanner
// Reports the smallest answer TTL of a DNS message fed one byte per item.
// ============================================================================
//
// The block takes a DNS message one byte per item, in order from offset zero,
// with last_byte set on the final byte, and gives exactly one result item per
// message: the smallest TTL among the answer records and the number of answer
// records whose TTL was compared. It reads the question and answer counts from
// the 12-byte header, skips question names (label lengths, a two-byte pointer
// for any byte with both top bits set, a zero byte as the end) plus QTYPE and
// QCLASS, and for each answer skips the name, collects the ten fixed bytes and
// skips the record data. The minimum reads 0 when the header is short, when
// the answer count is zero, when no TTL was taken, or when it is all ones.
// Throughput is one byte per clock cycle, sustained, while the result side does not
// stall: every byte updates only small parser registers in the back part, which
// retires one queued byte per cycle. A byte accepted into the front stage is pushed
// into the queue and popped by the back part, and the result is registered when
// the final byte is popped. Only the final byte of a message can wait on a full
// result register; while it waits, the queue keeps taking input bytes until it
// fills.
//
`default_nettype none

module dns_min_ttl_scanner_core
    import dmts_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = DMTS_QUEUE_DEPTH
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      byte_valid,
    output logic           byte_stall,
    input  wire dmts_in_t  byte_item,
    output logic           result_valid,
    input  wire logic      result_stall,
    output dmts_out_t      result_item
);

    dmts_qstat_t qstat;
    logic        push;
    dmts_cls_t   push_item;
    logic        pop;
    dmts_cls_t   head_item;

    // Front part: input stage that tags zero bytes and name pointers.
    dmts_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .byte_item  (byte_item),
        .qstat      (qstat),
        .push       (push),
        .push_item  (push_item)
    );

    // Queue that lets the front keep accepting while the result side stalls.
    dmts_queue
    #(
        .DEPTH (QUEUE_DEPTH)
    )
    u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head_item (head_item),
        .qstat     (qstat)
    );

    // Back part: message walker and registered result.
    dmts_parser u_parser
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .qstat        (qstat),
        .head_item    (head_item),
        .pop          (pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_item  (result_item)
    );

endmodule

`default_nettype wire

FILE: sim/dns_min_ttl_scanner_core_test.sv
`timescale 1ns / 1ps
// ============================================================================
// DNS minimum TTL scanner testbench
// Streams whole, truncated and garbled DNS messages into the scanner one byte
// per item and checks every result item against a parser model kept in step
// with the accepted bytes.
// ============================================================================

module dns_min_ttl_scanner_core_test;
    import dmts_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int unsigned HOLD_AT      = 200;   // bytes taken before the long output hold
    localparam int unsigned HOLD_CYCLES  = 800;
    localparam int unsigned FIRST_BATCH  = 700;   // bytes queued before the sender pause
    localparam int unsigned BYTE_TARGET  = 1410;
    localparam int unsigned MSG_TARGET   = 12;
    localparam int unsigned PHASE_ONE    = 600;   // idle pattern switches at these byte counts
    localparam int unsigned PHASE_TWO    = 1200;
    localparam int unsigned DRAIN_CYCLES = 20;
    localparam int unsigned REPORT_LIMIT = 10;

    // A minimal well-formed message: no questions, one answer with a pointer
    // name and an all-ones TTL, and no record data.
    localparam logic [7:0] ALL_ONES_ANSWER [24] = '{
        8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'hFF, 8'hFF, 8'h00, 8'h00,
        8'hC0, 8'h0C, 8'h00, 8'h01, 8'h00, 8'h01, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00
    };

    logic      clk          = 1'b0;
    logic      rst_n        = 1'b0;
    logic      byte_valid   = 1'b0;
    logic      byte_stall;
    dmts_in_t  byte_item    = '0;
    logic      result_valid;
    logic      result_stall = 1'b0;
    dmts_out_t result_item;

    dns_min_ttl_scanner_core u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_valid   (byte_valid),
        .byte_stall   (byte_stall),
        .byte_item    (byte_item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_item  (result_item)
    );

    always #5 clk = ~clk;

    // Stimulus and scoreboard storage.
    dmts_in_t    byte_backlog[$];
    dmts_out_t   ttl_expected[$];
    logic [7:0]  msg_buf[$];
    dmts_out_t   ttl_front;

    int unsigned items_queued    = 0;
    int unsigned messages_queued = 0;
    int unsigned items_taken     = 0;
    int unsigned mismatches      = 0;
    int unsigned cycle_count     = 0;
    int unsigned hold_left       = 0;
    logic        hold_done       = 1'b0;

    // Parser model state, one copy for the message in flight.
    logic [3:0]  msg_phase;
    logic [3:0]  hdr_count;
    logic [15:0] qd_total;
    logic [15:0] an_total;
    logic [15:0] recs_left;
    logic [15:0] skip_count;
    logic [3:0]  fixed_idx;
    logic [31:0] ttl_acc;
    logic [31:0] ttl_min;
    logic [15:0] ttl_taken;

    // ------------------------------------------------------------------------
    // Parser model
    // ------------------------------------------------------------------------

    // Returns the model to its idle state: waiting for the first header byte.
    task automatic clear_scan();
        msg_phase  = PH_HEADER;
        hdr_count  = '0;
        qd_total   = '0;
        an_total   = '0;
        recs_left  = '0;
        skip_count = '0;
        fixed_idx  = '0;
        ttl_acc    = '0;
        ttl_min    = ALL_ONES32;
        ttl_taken  = '0;
    endtask

    task automatic close_answer();
        recs_left = recs_left - 16'd1;
        msg_phase = (recs_left == 16'd0) ? PH_DONE : PH_A_NAME;
    endtask

    // Advances the model by one accepted byte. On the final byte of a message
    // the expected result is queued and the model starts over.
    task automatic scan_byte(input dmts_in_t it);
        logic [7:0] b;
        logic       in_answer;
        dmts_out_t  res;
        b = it.byte_value;
        in_answer = (msg_phase == PH_A_NAME);
        case (msg_phase)
            PH_HEADER:
            begin
                if (hdr_count == OFS_QD_HI || hdr_count == OFS_QD_LO)
                    qd_total = {qd_total[7:0], b};
                else if (hdr_count == OFS_AN_HI || hdr_count == OFS_AN_LO)
                    an_total = {an_total[7:0], b};
                hdr_count = hdr_count + 4'd1;
                if (hdr_count == HEADER_LEN)
                begin
                    // With no answers the rest of the message cannot matter.
                    if (an_total == 16'd0)
                        msg_phase = PH_DONE;
                    else if (qd_total != 16'd0)
                    begin
                        recs_left = qd_total;
                        msg_phase = PH_Q_NAME;
                    end
                    else
                    begin
                        recs_left = an_total;
                        msg_phase = PH_A_NAME;
                    end
                end
            end
            PH_Q_NAME, PH_A_NAME:
            begin
                if (b == 8'h00)
                begin
                    if (in_answer)
                    begin
                        fixed_idx = '0;
                        msg_phase = PH_A_FIXED;
                    end
                    else
                    begin
                        skip_count = QTAIL_LEN;
                        msg_phase  = PH_Q_TAIL;
                    end
                end
                else if ((b & PTR_MASK) == PTR_MASK)
                    msg_phase = in_answer ? PH_A_PTR : PH_Q_PTR;
                else
                begin
                    // Anything else, including 0x40 to 0xBF, is a label length.
                    skip_count = {8'h00, b};
                    msg_phase  = in_answer ? PH_A_LABEL : PH_Q_LABEL;
                end
            end
            PH_Q_LABEL, PH_A_LABEL:
            begin
                skip_count = skip_count - 16'd1;
                if (skip_count == 16'd0)
                    msg_phase = (msg_phase == PH_A_LABEL) ? PH_A_NAME : PH_Q_NAME;
            end
            PH_Q_PTR:
            begin
                skip_count = QTAIL_LEN;
                msg_phase  = PH_Q_TAIL;
            end
            PH_Q_TAIL:
            begin
                skip_count = skip_count - 16'd1;
                if (skip_count == 16'd0)
                begin
                    recs_left = recs_left - 16'd1;
                    if (recs_left == 16'd0)
                    begin
                        recs_left = an_total;
                        msg_phase = (an_total == 16'd0) ? PH_DONE : PH_A_NAME;
                    end
                    else
                        msg_phase = PH_Q_NAME;
                end
            end
            PH_A_PTR:
            begin
                fixed_idx = '0;
                msg_phase = PH_A_FIXED;
            end
            PH_A_FIXED:
            begin
                if (fixed_idx >= FLD_TTL_FIRST && fixed_idx <= FLD_TTL_LAST)
                    ttl_acc = {ttl_acc[23:0], b};
                else if (fixed_idx == FLD_RDLEN_HI)
                    skip_count = {8'h00, b};
                if (fixed_idx == FIXED_LAST)
                begin
                    // All ten fixed bytes are in: the TTL counts now.
                    skip_count = {skip_count[7:0], b};
                    ttl_taken  = ttl_taken + 16'd1;
                    if (ttl_acc < ttl_min)
                        ttl_min = ttl_acc;
                    fixed_idx = '0;
                    if (skip_count == 16'd0)
                        close_answer();
                    else
                        msg_phase = PH_A_RDATA;
                end
                else
                    fixed_idx = fixed_idx + 4'd1;
            end
            PH_A_RDATA:
            begin
                skip_count = skip_count - 16'd1;
                if (skip_count == 16'd0)
                    close_answer();
            end
            default:
            begin
            end
        endcase
        if (it.last_byte)
        begin
            res.min_ttl       = (ttl_min == ALL_ONES32) ? 32'd0 : ttl_min;
            res.answers_taken = ttl_taken;
            ttl_expected = {ttl_expected, res};
            clear_scan();
        end
    endtask

    // ------------------------------------------------------------------------
    // Message builders
    // ------------------------------------------------------------------------

    // Appends one byte to the message under construction.
    task automatic put_byte(input logic [7:0] v);
        msg_buf = {msg_buf, v};
    endtask

    // Queues the first count bytes of msg_buf as one message.
    task automatic ship_message(input int unsigned count);
        dmts_in_t it;
        for (int unsigned i = 0; i < count; i++)
        begin
            it.byte_value = msg_buf[i];
            it.last_byte  = (i == count - 1);
            byte_backlog = {byte_backlog, it};
        end
        items_queued    += count;
        messages_queued += 1;
    endtask

    // A domain name: zero to two labels, then either a zero byte or a pointer.
    task automatic add_name();
        int unsigned labels;
        int unsigned len;
        labels = $urandom_range(0, 2);
        repeat (labels)
        begin
            if ($urandom_range(29) == 0)
                len = $urandom_range(8'h40, 8'hBF);
            else
                len = $urandom_range(1, 5);
            put_byte(8'(len));
            repeat (len)
                put_byte(8'($urandom));
        end
        if ($urandom_range(2) == 0)
        begin
            put_byte(8'($urandom_range(8'hC0, 8'hFF)));
            put_byte(8'($urandom));
        end
        else
            put_byte(8'h00);
    endtask

    // Most messages are well formed with random content; the rest are short
    // headers, noise, answerless, oversized counts or cut off anywhere.
    task automatic add_random_message();
        int unsigned pick;
        int unsigned qd;
        int unsigned an;
        int unsigned rdlen;
        int unsigned cut;
        logic [31:0] ttl;
        msg_buf.delete();
        pick = $urandom_range(99);
        if (pick < 6)
        begin
            repeat ($urandom_range(1, 11))
                put_byte(8'($urandom));
        end
        else if (pick < 12)
        begin
            repeat ($urandom_range(1, 48))
                put_byte(8'($urandom));
        end
        else
        begin
            qd = $urandom_range(0, 2);
            an = (pick < 18) ? 0 : $urandom_range(1, 3);
            if (pick >= 18 && pick < 22)
            begin
                // Counts far beyond what follows; the message ends mid-parse.
                qd = $urandom_range(0, 65535);
                an = $urandom_range(1, 65535);
            end
            repeat (4)
                put_byte(8'($urandom));
            put_byte(8'(qd >> 8));
            put_byte(8'(qd));
            put_byte(8'(an >> 8));
            put_byte(8'(an));
            repeat (4)
                put_byte(8'($urandom));
            repeat ((qd > 2) ? 2 : qd)
            begin
                add_name();
                repeat (4)
                    put_byte(8'($urandom));
            end
            repeat ((an > 3) ? 3 : an)
            begin
                add_name();
                repeat (4)
                    put_byte(8'($urandom));
                case ($urandom_range(7))
                    0:       ttl = 32'd0;
                    1:       ttl = ALL_ONES32;
                    2:       ttl = ALL_ONES32 - 32'd1;
                    3, 4:    ttl = $urandom_range(0, 3600);
                    default: ttl = $urandom;
                endcase
                for (int s = 24; s >= 0; s -= 8)
                    put_byte(8'(ttl >> s));
                rdlen = ($urandom_range(9) == 0) ? $urandom_range(0, 300)
                                                 : $urandom_range(0, 4);
                put_byte(8'(rdlen >> 8));
                put_byte(8'(rdlen));
                repeat (rdlen)
                    put_byte(8'($urandom));
            end
            if ($urandom_range(9) == 0)
            begin
                repeat ($urandom_range(1, 6))
                    put_byte(8'($urandom));
            end
        end
        cut = msg_buf.size();
        if ($urandom_range(6) == 0)
            cut = $urandom_range(1, msg_buf.size());
        ship_message(cut);
    endtask

    // ------------------------------------------------------------------------
    // Flow control
    // ------------------------------------------------------------------------

    // The idle pattern moves through three phases as the run progresses:
    // a busy receiver, then a sparse sender, then both at full rate.
    function automatic int unsigned sender_idle_pct();
        if (items_taken < PHASE_ONE)
            return 6;
        else if (items_taken < PHASE_TWO)
            return 63;
        return 0;
    endfunction

    function automatic int unsigned receiver_stall_pct();
        if (items_taken < PHASE_ONE)
            return 63;
        else if (items_taken < PHASE_TWO)
            return 6;
        return 0;
    endfunction

    // Byte driver. A new item is offered only once the current one has been
    // taken, so an offered item holds steady through any stall.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_valid <= 1'b0;
            byte_item  <= '0;
        end
        else if (!byte_valid || !byte_stall)
        begin
            if (byte_backlog.size() != 0 && $urandom_range(99) >= sender_idle_pct())
            begin
                byte_valid <= 1'b1;
                byte_item  <= byte_backlog.pop_front();
            end
            else
                byte_valid <= 1'b0;
        end
    end

    // Result stall. Once, early in the run, the output is held off for a long
    // stretch while bytes keep coming, so the block backs up into its input.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_stall <= 1'b0;
            hold_left    <= 0;
            hold_done    <= 1'b0;
        end
        else if (!hold_done && items_taken >= HOLD_AT)
        begin
            hold_done    <= 1'b1;
            hold_left    <= HOLD_CYCLES;
            result_stall <= 1'b1;
        end
        else if (hold_left != 0)
        begin
            hold_left    <= hold_left - 1;
            result_stall <= 1'b1;
        end
        else
            result_stall <= ($urandom_range(99) < receiver_stall_pct());
    end

    // ------------------------------------------------------------------------
    // Monitors
    // ------------------------------------------------------------------------

    // Every accepted byte advances the model.
    always @(posedge clk)
    begin
        if (rst_n && byte_valid && !byte_stall)
        begin
            scan_byte(byte_item);
            items_taken <= items_taken + 1;
        end
    end

    task automatic log_mismatch(input string what, input dmts_out_t want,
                                input dmts_out_t got);
        mismatches += 1;
        if (mismatches <= REPORT_LIMIT)
            $display("%0t: %s: expected min_ttl %0d answers_taken %0d, got %0d %0d",
                     $realtime, what, want.min_ttl, want.answers_taken,
                     got.min_ttl, got.answers_taken);
    endtask

    // Each taken result item is matched against the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            if (ttl_expected.size() == 0)
                log_mismatch("result with none expected", '0, result_item);
            else
            begin
                ttl_front = ttl_expected.pop_front();
                if (ttl_front.min_ttl !== result_item.min_ttl ||
                    ttl_front.answers_taken !== result_item.answers_taken)
                    log_mismatch("result differs", ttl_front, result_item);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAIL dns_min_ttl_scanner_core");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------

    // Blocks until every queued byte is taken and every result has arrived.
    task automatic wait_drained();
        while (items_taken != items_queued || ttl_expected.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        clear_scan();

        // Directed: a one-byte message that cannot hold a header, then the
        // smallest complete answer carrying an all-ones TTL.
        msg_buf.delete();
        put_byte(8'hFF);
        ship_message(1);
        msg_buf.delete();
        foreach (ALL_ONES_ANSWER[i])
            put_byte(ALL_ONES_ANSWER[i]);
        ship_message(msg_buf.size());

        while (items_queued < FIRST_BATCH)
            add_random_message();

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // The sender stops here until the block has handed back everything.
        wait_drained();
        while (items_queued < BYTE_TARGET || messages_queued < MSG_TARGET)
            add_random_message();

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && ttl_expected.size() == 0)
            $display("PASS dns_min_ttl_scanner_core");
        else
            $display("FAIL dns_min_ttl_scanner_core");
        $finish;
    end

endmodule

FILE: dns_min_ttl_scanner_core.f
rtl/dmts_pkg.sv
rtl/dmts_front.sv
rtl/dmts_queue.sv
rtl/dmts_parser.sv
rtl/dns_min_ttl_scanner_core.sv
sim/dns_min_ttl_scanner_core_test.sv
